### rtl/core/top_k_frequent_values_top_macros.svh
// Assertion macros for the top-k frequent values block.
// Used by top_k_frequent_values_top.sv under rtl/core; no other dependencies.
`ifndef TOP_K_FREQUENT_VALUES_TOP_MACROS_SVH
`define TOP_K_FREQUENT_VALUES_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset.
`define TKFV_ASSERT_ON(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent assertion on the block clock and reset.
`define TKFV_ASSERT(lbl, prop, msg) \
  `TKFV_ASSERT_ON(lbl, clk_i, rst_ni, prop, msg)
`else
`define TKFV_ASSERT_ON(lbl, clk, rstn, prop, msg)
`define TKFV_ASSERT(lbl, prop, msg)
`endif

`endif

### rtl/core/tkfv_pkg.sv
// Shared constants and types of the top-k frequent values block.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package tkfv_pkg;

  // Fixed field widths.
  localparam int ValueWidth    = 32;
  localparam int TopCountWidth = 7;

  // Defaults for the top-level parameters.
  localparam int TableDepthDefault = 64;
  localparam int CountWidthDefault = 16;

  // Upper bound on results per stream and reset value of top_count.
  localparam int                       MaxResults    = 64;
  localparam logic [TopCountWidth-1:0] TopCountReset = TopCountWidth'(1);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RANK,
    ST_SCAN,
    ST_PUT
  } state_e;

endpackage

`default_nettype wire

### rtl/core/tkfv_table.sv
// Value/count table storage: one write port, one read port, registered read data.
// Depends on tkfv_pkg for default widths.
`default_nettype none

module tkfv_table #(
  parameter int DEPTH  = tkfv_pkg::TableDepthDefault,
  parameter int DATA_W = tkfv_pkg::ValueWidth + tkfv_pkg::CountWidthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/top_k_frequent_values_top.sv
// Top level of the top-k frequent values block; uses tkfv_pkg and tkfv_table.
// Per item: one read per stored distinct value on the single table read port, after the
// accept cycle; a hit ends the search at the matching entry.
// End of stream: k is clamped, then k table scans, one per result; result stalls hold them.
// Reset clears control state, the distinct count and the overflow flag and sets top_count
// to 1; table contents are left as they are and need no clearing pass.
`default_nettype none
`include "top_k_frequent_values_top_macros.svh"

module top_k_frequent_values_top #(
  parameter int TABLE_DEPTH = tkfv_pkg::TableDepthDefault,
  parameter int COUNT_WIDTH = tkfv_pkg::CountWidthDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration: top_count.
  input  wire logic                                  cfg_we_i,
  input  wire logic [tkfv_pkg::TopCountWidth-1:0]    cfg_wdata_i,
  // Input items.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic signed [tkfv_pkg::ValueWidth-1:0] s_axis_tdata, // [31:0] sample_value
  input  wire logic                                  s_axis_tlast, // stream_end
  // Result items.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic signed [tkfv_pkg::ValueWidth-1:0]     m_axis_tdata, // [31:0] ranked_value
  output logic                                       m_axis_tlast, // final_result
  output logic                                       m_axis_tuser  // [0] table_overflow
);

  localparam int VW     = tkfv_pkg::ValueWidth;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int KW     = (CNT_W > tkfv_pkg::TopCountWidth) ? CNT_W : tkfv_pkg::TopCountWidth;
  localparam int WORD_W = COUNT_WIDTH + VW;

  // Control state.
  tkfv_pkg::state_e                  state_q, state_d;
  logic [CNT_W-1:0]                  addr_q, addr_d;
  logic                              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]                  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]                  total_q, total_d;
  logic                              ovf_q, ovf_d;
  logic [tkfv_pkg::TopCountWidth-1:0] top_count_q;
  logic [KW-1:0]                     k_q, k_d;
  logic [KW-1:0]                     out_cnt_q, out_cnt_d;
  logic                              have_prev_q, have_prev_d;
  logic                              best_vld_q, best_vld_d;
  logic                              m_valid_q, m_valid_d;

  // Payload registers.
  logic [VW-1:0]          sample_q, sample_d;
  logic                   last_q, last_d;
  logic [COUNT_WIDTH-1:0] best_cnt_q, best_cnt_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [VW-1:0]          best_val_q, best_val_d;
  logic [COUNT_WIDTH-1:0] prev_cnt_q, prev_cnt_d;
  logic [IDX_W-1:0]       prev_idx_q, prev_idx_d;
  logic [VW-1:0]          out_val_q, out_val_d;
  logic                   out_last_q, out_last_d;
  logic                   out_ovf_q, out_ovf_d;

  // Table port.
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  // Decoded read data and compare results.
  logic [VW-1:0]          rd_value;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   rd_last;
  logic                   hit;
  logic                   eligible;
  logic                   better;
  logic                   m_free;
  logic                   issue;
  logic                   final_load;

  tkfv_table #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (WORD_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign rd_value  = mem_rdata[VW-1:0];
  assign rd_count  = mem_rdata[WORD_W-1:VW];
  assign count_inc = (rd_count == '1) ? rd_count : rd_count + COUNT_WIDTH'(1);
  assign rd_last   = rd_vld_q && ((CNT_W'(rd_idx_q) + CNT_W'(1)) == total_q);
  assign hit       = rd_vld_q && (rd_value == sample_q);
  // An entry ranks after the previous result: lower count, or same count and later index.
  assign eligible  = !have_prev_q || (rd_count < prev_cnt_q) ||
                     ((rd_count == prev_cnt_q) && (rd_idx_q > prev_idx_q));
  // Ascending scan keeps the earliest entry among equal counts.
  assign better    = !best_vld_q || (rd_count > best_cnt_q);
  assign m_free    = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == tkfv_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

  // Next state, table access and result loading.
  always_comb begin
    logic [KW-1:0] k_clamp;
    k_clamp     = KW'(top_count_q);
    state_d     = state_q;
    addr_d      = addr_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    out_cnt_d   = out_cnt_q;
    have_prev_d = have_prev_q;
    best_vld_d  = best_vld_q;
    m_valid_d   = m_valid_q;
    sample_d    = sample_q;
    last_d      = last_q;
    best_cnt_d  = best_cnt_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    prev_cnt_d  = prev_cnt_q;
    prev_idx_d  = prev_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = rd_idx_q;
    mem_wdata   = {count_inc, rd_value};
    issue       = 1'b0;
    final_load  = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      tkfv_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          sample_d = s_axis_tdata;
          last_d   = s_axis_tlast;
          addr_d   = '0;
          state_d  = tkfv_pkg::ST_SEARCH;
        end
      end

      // Linear search, one table read per cycle.
      tkfv_pkg::ST_SEARCH: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_q;
          mem_wdata = {count_inc, rd_value};
          state_d   = last_q ? tkfv_pkg::ST_RANK : tkfv_pkg::ST_IDLE;
        end else if ((total_q == '0) || rd_last) begin
          if (total_q < CNT_W'(TABLE_DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = total_q[IDX_W-1:0];
            mem_wdata = {COUNT_WIDTH'(1), sample_q};
            total_d   = total_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = last_q ? tkfv_pkg::ST_RANK : tkfv_pkg::ST_IDLE;
        end else begin
          issue = (addr_q < total_q);
        end
      end

      // Clamp k and prepare the first ranking scan, or end the stream at once if k is zero.
      tkfv_pkg::ST_RANK: begin
        if (k_clamp > KW'(tkfv_pkg::MaxResults)) begin
          k_clamp = KW'(tkfv_pkg::MaxResults);
        end
        if (k_clamp > KW'(total_q)) begin
          k_clamp = KW'(total_q);
        end
        k_d         = k_clamp;
        out_cnt_d   = '0;
        have_prev_d = 1'b0;
        best_vld_d  = 1'b0;
        addr_d      = '0;
        if (k_clamp == '0) begin
          total_d = '0;
          ovf_d   = 1'b0;
          state_d = tkfv_pkg::ST_IDLE;
        end else begin
          state_d = tkfv_pkg::ST_SCAN;
        end
      end

      // Find the best entry ranked after the previous result.
      tkfv_pkg::ST_SCAN: begin
        if (rd_vld_q && eligible && better) begin
          best_vld_d = 1'b1;
          best_cnt_d = rd_count;
          best_idx_d = rd_idx_q;
          best_val_d = rd_value;
        end
        if (rd_last) begin
          state_d = tkfv_pkg::ST_PUT;
        end else begin
          issue = (addr_q < total_q);
        end
      end

      // Hand the result to the output register.
      tkfv_pkg::ST_PUT: begin
        if (m_free) begin
          m_valid_d   = 1'b1;
          out_val_d   = best_val_q;
          out_last_d  = (out_cnt_q + KW'(1)) == k_q;
          out_ovf_d   = ovf_q;
          prev_cnt_d  = best_cnt_q;
          prev_idx_d  = best_idx_q;
          have_prev_d = 1'b1;
          out_cnt_d   = out_cnt_q + KW'(1);
          if ((out_cnt_q + KW'(1)) == k_q) begin
            final_load = 1'b1;
            total_d    = '0;
            ovf_d      = 1'b0;
            state_d    = tkfv_pkg::ST_IDLE;
          end else begin
            addr_d     = '0;
            best_vld_d = 1'b0;
            state_d    = tkfv_pkg::ST_SCAN;
          end
        end
      end

      default: begin
        state_d = tkfv_pkg::ST_IDLE;
      end
    endcase

    if (issue) begin
      addr_d = addr_q + CNT_W'(1);
    end
  end

  assign rd_vld_d = issue;
  assign rd_idx_d = issue ? addr_q[IDX_W-1:0] : rd_idx_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkfv_pkg::ST_IDLE;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      top_count_q <= tkfv_pkg::TopCountReset;
      k_q         <= '0;
      out_cnt_q   <= '0;
      have_prev_q <= 1'b0;
      best_vld_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      if (cfg_we_i) begin
        top_count_q <= cfg_wdata_i;
      end
      k_q         <= k_d;
      out_cnt_q   <= out_cnt_d;
      have_prev_q <= have_prev_d;
      best_vld_q  <= best_vld_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    last_q     <= last_d;
    best_cnt_q <= best_cnt_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    prev_cnt_q <= prev_cnt_d;
    prev_idx_q <= prev_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  // Checks on table bookkeeping and result counting.
  `TKFV_ASSERT(a_total_bound, (total_q <= CNT_W'(TABLE_DEPTH)), "distinct count exceeds table depth")
  `TKFV_ASSERT(a_ovf_when_full, ($rose(ovf_q) |-> ($past(total_q) == CNT_W'(TABLE_DEPTH))), "overflow set with room left")
  `TKFV_ASSERT(a_out_cnt_bound, (out_cnt_q <= k_q), "more results emitted than requested")
  `TKFV_ASSERT(a_final_clears, (final_load |=> (total_q == '0) && !ovf_q), "table not cleared after last result")

endmodule

`default_nettype wire

### test/top_k_frequent_values_top_tb.sv
// Self-checking testbench for top_k_frequent_values_top: directed streams, a table
// overflow and random streams, checked against a predictor of the ranking or, for some
// script rows, a fixed expected value. Depends on tkfv_pkg and the RTL under rtl/core; needs no files or arguments.
`timescale 1ns / 1ps

module top_k_frequent_values_top_tb;

  localparam int VALUE_W      = tkfv_pkg::ValueWidth;
  localparam int TOP_COUNT_W  = tkfv_pkg::TopCountWidth;
  localparam int TABLE_DEPTH  = tkfv_pkg::TableDepthDefault;
  localparam int COUNT_WIDTH  = tkfv_pkg::CountWidthDefault;
  // Wait left after the last expected item before a configuration write, so the block can finish.
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 236;
  localparam int NUM_ROWS      = 24;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_SET_K
  } row_kind_e;

  // One row of the directed script; want is used only when typed is set.
  typedef struct packed {
    row_kind_e           kind;
    logic [VALUE_W-1:0]  value;
    logic                last;
    logic                typed;
    logic [VALUE_W-1:0]  want;
  } row_t;

  // One ranked item as it leaves the block.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               final_res;
    logic               overflow;
  } rank_t;

  // Directed script. Reset leaves k at 1, so the first rows each give one item.
  localparam row_t SCRIPT [NUM_ROWS] = '{
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SET_K,  32'd64,        1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd5,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd5,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd5,         1'b1, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd7,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd9,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd9,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd7,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd3,         1'b1, 1'b0, 32'h0},
    '{ROW_SET_K,  32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd11,        1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd12,        1'b1, 1'b0, 32'h0},
    '{ROW_SET_K,  32'd2,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd42,        1'b1, 1'b1, 32'd42},
    '{ROW_SAMPLE, 32'd4,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd6,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'd6,         1'b1, 1'b0, 32'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [TOP_COUNT_W-1:0] cfg_wdata = '0;
  logic s_valid = 1'b0;
  logic signed [VALUE_W-1:0] s_data = '0;
  logic s_last = 1'b0;
  logic m_ready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic signed [VALUE_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  // Both sides draw random waits while this is set.
  bit idle_en = 1'b1;

  // Predictor state: the table of distinct values, their counts and the current k.
  logic [VALUE_W-1:0]     seen_values [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] seen_counts [TABLE_DEPTH];
  int unsigned            seen_total;
  bit                     overflow_flag;
  logic [TOP_COUNT_W-1:0] top_count_q;

  rank_t       expected_ranks [$];
  int unsigned samples_sent;
  int unsigned ranks_checked;
  int unsigned mismatch_count;

  top_k_frequent_values_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),        // [31:0] sample_value
    .s_axis_tlast (s_last),        // stream_end
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),  // [31:0] ranked_value
    .m_axis_tlast (m_axis_tlast),  // final_result
    .m_axis_tuser (m_axis_tuser)   // [0] table_overflow
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Counts one sample into the table; on the end flag ranks the table stably by count,
  // most frequent first, and appends the top k to dest before starting a fresh stream.
  task automatic predict_sample(input logic [VALUE_W-1:0] v, input bit last,
                                ref rank_t dest[$]);
    bit          found;
    bit          taken [TABLE_DEPTH];
    int unsigned k;
    int unsigned pick;
    rank_t       entry;
    found = 1'b0;
    for (int i = 0; i < seen_total; i++) begin
      if (!found && seen_values[i] == v) begin
        found = 1'b1;
        if (seen_counts[i] != '1) seen_counts[i]++;
      end
    end
    if (!found) begin
      if (seen_total < TABLE_DEPTH) begin
        seen_values[seen_total] = v;
        seen_counts[seen_total] = COUNT_WIDTH'(1);
        seen_total++;
      end else begin
        overflow_flag = 1'b1;
      end
    end
    if (!last) return;

    k = top_count_q;
    if (k > seen_total) k = seen_total;
    if (k > tkfv_pkg::MaxResults) k = tkfv_pkg::MaxResults;
    for (int i = 0; i < TABLE_DEPTH; i++) taken[i] = 1'b0;
    // Strictly greater wins, so among equal counts the earliest entry goes first.
    for (int r = 0; r < k; r++) begin
      pick = TABLE_DEPTH;
      for (int i = 0; i < seen_total; i++) begin
        if (!taken[i] && (pick == TABLE_DEPTH || seen_counts[i] > seen_counts[pick])) begin
          pick = i;
        end
      end
      taken[pick] = 1'b1;
      entry.value     = seen_values[pick];
      entry.final_res = (r == k - 1);
      entry.overflow  = overflow_flag;
      dest.push_back(entry);
    end
    seen_total    = 0;
    overflow_flag = 1'b0;
  endtask

  // Presents one sample after a random gap and returns at the edge that accepts it.
  task automatic send_sample(input logic [VALUE_W-1:0] v, input bit last);
    int unsigned gap;
    gap = idle_en ? $urandom_range(16) : 0;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= v;
    s_last  <= last;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic feed(input logic [VALUE_W-1:0] v, input bit last);
    send_sample(v, last);
    predict_sample(v, last, expected_ranks);
  endtask

  // Stops sending, waits for every expected item, then lets the block finish its work.
  task automatic quiesce();
    s_valid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_top_count(input logic [TOP_COUNT_W-1:0] k);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    top_count_q = k;
  endtask

  // Result side: random stalls, then each accepted item is checked against the oldest one
  // expected.
  initial begin : result_side
    int unsigned stall;
    rank_t       want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_en ? $urandom_range(16) : 0;
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(posedge clk_i);
      ranks_checked++;
      if (expected_ranks.size() == 0) begin
        $error("ranked item %h with no item expected", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_ranks.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("ranked_value: expected %h, got %h", want.value, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.final_res) begin
          $error("final_result: expected %b, got %b", want.final_res, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.overflow) begin
          $error("table_overflow: expected %b, got %b", want.overflow, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when nothing has moved on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready) === 1'b1 || (m_axis_tvalid && m_ready) === 1'b1) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    row_t               row;
    rank_t              scratch [$];
    rank_t              entry;
    logic [VALUE_W-1:0] pool [8];
    logic [VALUE_W-1:0] base;
    int unsigned        pool_size;
    int unsigned        len;
    int unsigned        streams;
    int unsigned        random_start;

    top_count_q    = tkfv_pkg::TopCountReset;
    seen_total     = 0;
    overflow_flag  = 1'b0;
    samples_sent   = 0;
    ranks_checked  = 0;
    mismatch_count = 0;
    streams        = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script: field extremes, ties, k of zero and k above the distinct count.
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = SCRIPT[r];
      if (row.kind == ROW_SET_K) begin
        set_top_count(row.value[TOP_COUNT_W-1:0]);
      end else if (row.typed) begin
        send_sample(row.value, row.last);
        predict_sample(row.value, row.last, scratch);
        scratch.delete();
        entry.value     = row.want;
        entry.final_res = 1'b1;
        entry.overflow  = 1'b0;
        expected_ranks.push_back(entry);
      end else begin
        feed(row.value, row.last);
      end
    end

    // Random streams, mostly small pools of values so that counts and ties build up.
    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_ITEMS) begin
      streams++;
      if (streams == 3) begin
        // Overflowing stream at the largest k: 66 distinct values, then repeats.
        set_top_count(TOP_COUNT_W'(64));
        base = $urandom;
        for (int i = 0; i < TABLE_DEPTH + 2; i++) feed(base + i, 1'b0);
        feed(base + 3, 1'b0);
        feed(base + 3, 1'b0);
        feed(base + TABLE_DEPTH + 1, 1'b0);
        feed(base, 1'b1);
      end else begin
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0: set_top_count(TOP_COUNT_W'(1));
            1: set_top_count(TOP_COUNT_W'(64));
            2: set_top_count(TOP_COUNT_W'($urandom_range(1, 8)));
            default: set_top_count(TOP_COUNT_W'($urandom_range(1, 64)));
          endcase
        end
        idle_en = ($urandom_range(4) != 0);
        len = $urandom_range(1, 16);
        if ($urandom_range(9) == 0) begin
          // Noise: every value fresh.
          for (int i = 0; i < len; i++) feed($urandom, i == len - 1);
        end else begin
          pool_size = $urandom_range(1, 6);
          for (int i = 0; i < pool_size; i++) begin
            case ($urandom_range(9))
              0: pool[i] = 32'h8000_0000;
              1: pool[i] = 32'h7FFF_FFFF;
              2: pool[i] = 32'h0000_0000;
              default: pool[i] = $urandom;
            endcase
          end
          for (int i = 0; i < len; i++) feed(pool[$urandom_range(pool_size - 1)], i == len - 1);
        end
        // Now and then hold the sender until the block has delivered everything.
        if ($urandom_range(5) == 0) quiesce();
      end
    end

    idle_en = 1'b1;
    quiesce();
    $display("Sent %0d samples (%0d random streams) and checked %0d ranked items.",
             samples_sent, streams, ranks_checked);
    $display("Covered k of 0, 1, 2 and 64, value extremes, ties and a full table.");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
